FILE: src/mfa_pkg.sv
package mfa_pkg;

  localparam int unsigned LIMB_COUNT = 4;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned WORD_COUNT = 8;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_NEG = 2'd2,
    OP_MUL = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PB,
    S_ADD,
    S_NEG,
    S_MUL,
    S_MTOP,
    S_MQ,
    S_RED,
    S_RTOP,
    S_FIN,
    S_OUT
  } state_e;

  // field prime, 32-bit words, least significant first
  localparam logic [WORD_W-1:0] PRIME_W [WORD_COUNT] = '{
    32'hd87cfd47, 32'h3c208c16, 32'h6871ca8d, 32'h97816a91,
    32'h8181585d, 32'hb85045b6, 32'he131a029, 32'h30644e72
  };

  // -p^-1 mod 2^32
  localparam logic [WORD_W-1:0] NP0 = 32'he4866389;

endpackage

FILE: src/mfa_mac.sv
module mfa_mac (
  input  logic [mfa_pkg::WORD_W-1:0]   x_i,
  input  logic [mfa_pkg::WORD_W-1:0]   y_i,
  input  logic [mfa_pkg::WORD_W-1:0]   z_i,
  input  logic [mfa_pkg::WORD_W-1:0]   c_i,
  output logic [2*mfa_pkg::WORD_W-1:0] p_o
);

  assign p_o = (2*mfa_pkg::WORD_W)'(x_i) * (2*mfa_pkg::WORD_W)'(y_i)
             + (2*mfa_pkg::WORD_W)'(z_i) + (2*mfa_pkg::WORD_W)'(c_i);

endmodule

FILE: src/montgomery_field_alu_256.sv
// Channel   Ports                                          Direction
// request   start_i, operation_i, a_limb_i, b_limb_i,      in
//           last_limb_i; taken when start_i & !busy_o
// result    result_valid_o, result_limb_o, result_last_o   out, one cycle each
//
// An unmarked limb is stored and busy_o stays low.
// A marked limb starts the operation: add/subtract/negate, or Montgomery multiply,
// all over one 32x32 multiply-add and one 32-bit adder (word-serial CIOS), then
// final reduction and the 4 result limbs.
// Reset clears the sequencer and limb counter; operand stores are not cleared.
// The receiver cannot stall: results leave on consecutive cycles.
module montgomery_field_alu_256 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  operation_i,
  input  logic [63:0] a_limb_i,
  input  logic [63:0] b_limb_i,
  input  logic        last_limb_i,
  output logic        result_valid_o,
  output logic [63:0] result_limb_o,
  output logic        result_last_o
);

  localparam int unsigned W = mfa_pkg::WORD_W;

  mfa_pkg::state_e state_q, state_d;
  mfa_pkg::op_e    op_q, op_d;
  logic [63:0]  a_q [mfa_pkg::LIMB_COUNT];
  logic [63:0]  b_q [mfa_pkg::LIMB_COUNT];
  logic [1:0]   cnt_q, cnt_d;
  logic [2:0]   j_q, j_d, i_q, i_d;
  logic [W-1:0] t_q [mfa_pkg::WORD_COUNT];
  logic [W-1:0] t_d [mfa_pkg::WORD_COUNT];
  logic [W-1:0] d_q [mfa_pkg::WORD_COUNT];
  logic [W-1:0] d_d [mfa_pkg::WORD_COUNT];
  logic [W-1:0] t8_q, t8_d, mc_q, mc_d, m_q, m_d;
  logic         top_q, top_d, head_q, head_d, sel_q, sel_d;

  logic         accept;
  logic [W-1:0] a_w, b_wj, b_wi, p_w;
  logic [W-1:0] ax, ay, mx, my, mz, mcin;
  logic         aci;
  logic [W:0]   asum;
  logic [2*W-1:0] mprod;
  logic [2:0]   ri;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != mfa_pkg::S_IDLE);

  assign a_w  = a_q[j_q[2:1]][{j_q[0], 5'b0} +: W];
  assign b_wj = b_q[j_q[2:1]][{j_q[0], 5'b0} +: W];
  assign b_wi = b_q[i_q[2:1]][{i_q[0], 5'b0} +: W];
  assign p_w  = mfa_pkg::PRIME_W[j_q];

  assign asum = {1'b0, ax} + {1'b0, ay} + {{W{1'b0}}, aci};

  mfa_mac u_mac (
    .x_i(mx),
    .y_i(my),
    .z_i(mz),
    .c_i(mcin),
    .p_o(mprod)
  );

  always_comb begin
    ax = t_q[j_q];
    ay = ~p_w;
    aci = mc_q[0];
    mx = a_w;
    my = b_wi;
    mz = t_q[j_q];
    mcin = mc_q;
    case (state_q)
      mfa_pkg::S_PB: begin
        ax = p_w;
        ay = ~b_wj;
      end
      mfa_pkg::S_NEG: begin
        ax = p_w;
        ay = ~a_w;
      end
      mfa_pkg::S_ADD: begin
        ax = a_w;
        ay = (op_q == mfa_pkg::OP_SUB) ? t_q[j_q] : b_wj;
      end
      mfa_pkg::S_MTOP, mfa_pkg::S_RTOP: begin
        ax = t8_q;
        ay = mc_q;
        aci = 1'b0;
      end
      mfa_pkg::S_MQ: begin
        mx = t_q[0];
        my = mfa_pkg::NP0;
        mz = '0;
        mcin = '0;
      end
      mfa_pkg::S_RED: begin
        mx = m_q;
        my = p_w;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    op_d = op_q;
    cnt_d = cnt_q;
    j_d = j_q;
    i_d = i_q;
    t_d = t_q;
    d_d = d_q;
    t8_d = t8_q;
    mc_d = mc_q;
    m_d = m_q;
    top_d = top_q;
    head_d = head_q;
    sel_d = sel_q;
    ri = j_q - 3'd1;
    case (state_q)
      mfa_pkg::S_IDLE: begin
        if (accept) begin
          if (!last_limb_i) begin
            cnt_d = cnt_q + 2'd1;
          end else begin
            cnt_d = '0;
            op_d = mfa_pkg::op_e'(operation_i);
            j_d = '0;
            i_d = '0;
            head_d = 1'b0;
            case (mfa_pkg::op_e'(operation_i))
              mfa_pkg::OP_ADD: begin
                state_d = mfa_pkg::S_ADD;
                mc_d = '0;
              end
              mfa_pkg::OP_SUB: begin
                state_d = mfa_pkg::S_PB;
                mc_d = W'(1);
              end
              mfa_pkg::OP_NEG: begin
                state_d = mfa_pkg::S_NEG;
                mc_d = W'(1);
              end
              default: begin
                state_d = mfa_pkg::S_MUL;
                mc_d = '0;
                for (int k = 0; k < mfa_pkg::WORD_COUNT; k++) t_d[k] = '0;
                t8_d = '0;
                top_d = 1'b0;
              end
            endcase
          end
        end
      end
      mfa_pkg::S_PB, mfa_pkg::S_NEG, mfa_pkg::S_ADD: begin
        t_d[j_q] = asum[W-1:0];
        mc_d = W'(asum[W]);
        j_d = j_q + 3'd1;
        if (j_q == 3'd7) begin
          if (state_q == mfa_pkg::S_PB) begin
            state_d = mfa_pkg::S_ADD;
            mc_d = '0;
          end else begin
            state_d = mfa_pkg::S_FIN;
            head_d = (state_q == mfa_pkg::S_ADD) ? asum[W] : 1'b0;
            mc_d = W'(1);
          end
        end
      end
      mfa_pkg::S_MUL: begin
        t_d[j_q] = mprod[W-1:0];
        mc_d = mprod[2*W-1:W];
        j_d = j_q + 3'd1;
        if (j_q == 3'd7) state_d = mfa_pkg::S_MTOP;
      end
      mfa_pkg::S_MTOP: begin
        t8_d = asum[W-1:0];
        top_d = asum[W];
        mc_d = '0;
        state_d = mfa_pkg::S_MQ;
      end
      mfa_pkg::S_MQ: begin
        m_d = mprod[W-1:0];
        j_d = '0;
        state_d = mfa_pkg::S_RED;
      end
      mfa_pkg::S_RED: begin
        if (j_q != 3'd0) t_d[ri] = mprod[W-1:0];
        mc_d = mprod[2*W-1:W];
        j_d = j_q + 3'd1;
        if (j_q == 3'd7) state_d = mfa_pkg::S_RTOP;
      end
      mfa_pkg::S_RTOP: begin
        t_d[7] = asum[W-1:0];
        t8_d = W'(top_q) + W'(asum[W]);
        top_d = 1'b0;
        j_d = '0;
        if (i_q == 3'd7) begin
          state_d = mfa_pkg::S_FIN;
          head_d = |t8_d;
          mc_d = W'(1);
        end else begin
          state_d = mfa_pkg::S_MUL;
          i_d = i_q + 3'd1;
          mc_d = '0;
        end
      end
      mfa_pkg::S_FIN: begin
        d_d[j_q] = asum[W-1:0];
        mc_d = W'(asum[W]);
        j_d = j_q + 3'd1;
        if (j_q == 3'd7) begin
          sel_d = head_q | asum[W];
          state_d = mfa_pkg::S_OUT;
        end
      end
      mfa_pkg::S_OUT: begin
        j_d = j_q + 3'd1;
        if (j_q[1:0] == 2'd3) state_d = mfa_pkg::S_IDLE;
      end
      default: state_d = mfa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mfa_pkg::S_IDLE;
      cnt_q <= '0;
      j_q <= '0;
      i_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      j_q <= j_d;
      i_q <= i_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_q[cnt_q] <= a_limb_i;
      b_q[cnt_q] <= b_limb_i;
    end
    op_q <= op_d;
    t_q <= t_d;
    d_q <= d_d;
    t8_q <= t8_d;
    mc_q <= mc_d;
    m_q <= m_d;
    top_q <= top_d;
    head_q <= head_d;
    sel_q <= sel_d;
  end

  assign result_valid_o = (state_q == mfa_pkg::S_OUT);
  assign result_last_o  = result_valid_o && (j_q[1:0] == 2'd3);
  assign result_limb_o  = sel_q ? {d_q[{j_q[1:0], 1'b1}], d_q[{j_q[1:0], 1'b0}]}
                                : {t_q[{j_q[1:0], 1'b1}], t_q[{j_q[1:0], 1'b0}]};

  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o) else $error("result outside busy window");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_last_o |=> !busy_o) else $error("busy after final limb");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && last_limb_i) |=> busy_o && !result_valid_o)
    else $error("operation did not start");

  a_first_limb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_valid_o) |-> !result_last_o) else $error("last flag on first limb");

endmodule
